@@ rtl/som_pkg.sv @@
// ----------------------------------------------------------------------------
// som_pkg: shared types, constants and helpers for the substring matcher
// Holds the pattern geometry, register indexes, the structs passed between
// the window cells, the occurrence tracker and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package som_pkg;

    // Pattern and window geometry
    localparam int MAX_PATTERN   = 8;
    localparam int WINDOW_CELLS  = MAX_PATTERN - 1;
    localparam int LEN_BITS      = 4;
    localparam int PAT_IDX_BITS  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int PATTERN_BITS  = MAX_PATTERN * 8;

    // Position and count widths
    localparam int POSITION_BITS = 16;
    localparam int REPORT_BITS   = 16;
    localparam int COUNT_BITS    = 16;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // Configuration port
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 64;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_BYTES  = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_LENGTH = 1'b1;
    localparam logic [LEN_BITS-1:0]       PATTERN_LENGTH_RST = 4'd1;

    typedef logic [POSITION_BITS-1:0] position_t;

    // Shift and clear strobes shared by every stateful part of the chain
    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctrl_t;

    // One byte of history travelling from cell to cell
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } link_t;

    // Per-transaction result from the occurrence tracker
    typedef struct packed {
        logic                   match_found;
        logic [REPORT_BITS-1:0] match_start;
        logic [COUNT_BITS-1:0]  match_count;
        logic                   found_any;
        logic [REPORT_BITS-1:0] first_start;
    } track_res_t;

    // Lengths of zero count as one, lengths above the maximum as the maximum.
    function automatic logic [LEN_BITS-1:0] effective_length(input logic [LEN_BITS-1:0] len);
        logic [LEN_BITS-1:0] res;
        res = len;
        if (len == '0)
        begin
            res = LEN_BITS'(1);
        end
        else if (len > LEN_BITS'(MAX_PATTERN))
        begin
            res = LEN_BITS'(MAX_PATTERN);
        end
        return res;
    endfunction

    // Selects one pattern character, character 0 in the low byte.
    function automatic logic [7:0] pattern_byte(input logic [PATTERN_BITS-1:0] pat,
                                                input logic [PAT_IDX_BITS-1:0] idx);
        return pat[idx * 8 +: 8];
    endfunction

endpackage

`default_nettype wire

@@ rtl/som_if.sv @@
// ----------------------------------------------------------------------------
// som_if: valid/ready channels of the substring matcher
// One interface for the incoming text bytes and one for the results.
// ----------------------------------------------------------------------------
`default_nettype none

interface som_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface som_result_if;
    logic        valid;
    logic        ready;
    logic        match_found;
    logic [15:0] match_start;
    logic [15:0] match_count;
    logic        found_any;
    logic [15:0] first_start;
    logic        is_last;

    modport source (output valid, output match_found, output match_start,
                    output match_count, output found_any, output first_start,
                    output is_last, input ready);
    modport sink   (input valid, input match_found, input match_start,
                    input match_count, input found_any, input first_start,
                    input is_last, output ready);
endinterface

`default_nettype wire

@@ rtl/substring_occurrence_matcher_core.sv @@
// ----------------------------------------------------------------------------
// substring_occurrence_matcher_core: streaming search for every occurrence
// Compares each text byte, together with a chain of history cells, against a
// configured pattern of one to eight bytes and reports each occurrence.
//
//   Channel     Kind          Handshake     Payload
//   text_in     sink          valid/ready   text_byte, end_of_text
//   result_out  source        valid/ready   match_found, match_start,
//                                           match_count, found_any,
//                                           first_start, is_last
//   cfg_*       write port    write enable  cfg_index, cfg_data
//
// One byte is accepted per cycle while the output register is empty or being read;
// its result appears in the output register on the next cycle.
// The seven window cells shift on every accepted transaction and all compare
// in parallel within that cycle.
// rst_n clears the window, the per-string counters and the output valid flag;
// the pattern returns to zero and the length to one.
// When result_out stalls, text_in is held off only while a result is waiting.
// ----------------------------------------------------------------------------
`default_nettype none

module substring_occurrence_matcher_core
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    som_text_if.sink                                 text_in,
    som_result_if.source                             result_out,
    input  wire logic                                cfg_write_en,
    input  wire logic [som_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire logic [som_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

    logic [som_pkg::PATTERN_BITS-1:0]   pattern_reg;
    logic [som_pkg::PATTERN_BITS-1:0]   pattern_next;
    logic [som_pkg::LEN_BITS-1:0]       length_reg;
    logic [som_pkg::LEN_BITS-1:0]       length_next;
    logic [som_pkg::LEN_BITS-1:0]       eff_len;

    logic                               accept;
    som_pkg::cell_ctrl_t                ctrl;
    som_pkg::link_t                     win_link [som_pkg::WINDOW_CELLS+1];
    logic [som_pkg::WINDOW_CELLS-1:0]   cell_ok;
    logic                               last_ok;
    logic                               hit;
    som_pkg::track_res_t                track_res;

    logic                               out_valid_reg;
    logic                               out_valid_next;
    som_pkg::track_res_t                res_reg;
    logic                               is_last_reg;

    // Configuration registers
    always_comb
    begin
        pattern_next = pattern_reg;
        length_next  = length_reg;
        if (cfg_write_en)
        begin
            unique case (cfg_index)
                som_pkg::REG_PATTERN_BYTES:
                begin
                    pattern_next = cfg_data[som_pkg::PATTERN_BITS-1:0];
                end
                som_pkg::REG_PATTERN_LENGTH:
                begin
                    length_next = cfg_data[som_pkg::LEN_BITS-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg <= '0;
            length_reg  <= som_pkg::PATTERN_LENGTH_RST;
        end
        else
        begin
            pattern_reg <= pattern_next;
            length_reg  <= length_next;
        end
    end

    assign eff_len = som_pkg::effective_length(length_reg);

    // Input handshake: a new byte is taken whenever the output register frees up.
    assign text_in.ready = !out_valid_reg || result_out.ready;
    assign accept        = text_in.valid && text_in.ready;
    assign ctrl.shift    = accept;
    assign ctrl.clear    = text_in.end_of_text;

    // The newest byte enters the chain at its head.
    assign win_link[0].valid = 1'b1;
    assign win_link[0].data  = text_in.text_byte;

    // History window: cell k holds the byte k+1 places back.
    for (genvar k = 0; k < som_pkg::WINDOW_CELLS; k++)
    begin : g_cell
        logic [som_pkg::PAT_IDX_BITS-1:0] ref_idx;
        logic                             in_use;

        assign ref_idx = som_pkg::PAT_IDX_BITS'(eff_len - som_pkg::LEN_BITS'(k + 2));
        assign in_use  = som_pkg::LEN_BITS'(k + 2) <= eff_len;

        som_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .link_in  (win_link[k]),
            .ref_byte (som_pkg::pattern_byte(pattern_reg, ref_idx)),
            .in_use   (in_use),
            .link_out (win_link[k+1]),
            .ok       (cell_ok[k])
        );
    end

    // The current byte must match the last pattern character.
    assign last_ok = text_in.text_byte
                  == som_pkg::pattern_byte(pattern_reg,
                         som_pkg::PAT_IDX_BITS'(eff_len - som_pkg::LEN_BITS'(1)));
    assign hit     = last_ok && (&cell_ok);

    som_tracker u_tracker
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .hit     (hit),
        .eff_len (eff_len),
        .res     (track_res)
    );

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_out.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg     <= track_res;
            is_last_reg <= text_in.end_of_text;
        end
    end

    assign result_out.valid       = out_valid_reg;
    assign result_out.match_found = res_reg.match_found;
    assign result_out.match_start = res_reg.match_start;
    assign result_out.match_count = res_reg.match_count;
    assign result_out.found_any   = res_reg.found_any;
    assign result_out.first_start = res_reg.first_start;
    assign result_out.is_last     = is_last_reg;

    // A transaction without a match reports a zero start position.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !res_reg.match_found) |-> (res_reg.match_start == '0))
        else $error("match_start not zero without a match");

    // Before any occurrence the count and first position stay zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !res_reg.found_any)
            |-> (res_reg.match_count == '0 && res_reg.first_start == '0))
        else $error("count or first position set before any occurrence");

    // A match always leaves found_any set and a non-zero count.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.match_found)
            |-> (res_reg.found_any && res_reg.match_count != '0))
        else $error("match without found_any or count");

    // End of text empties the history window.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && text_in.end_of_text)
            |=> (!win_link[1].valid && !win_link[som_pkg::WINDOW_CELLS].valid))
        else $error("history window not cleared after end of text");

    // A byte taken while a result waits implies that result is being consumed.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && out_valid_reg) |-> result_out.ready)
        else $error("result overwritten before it was taken");

endmodule

`default_nettype wire

@@ rtl/som_cell.sv @@
// ----------------------------------------------------------------------------
// som_cell: one byte of the history window
// Holds a text byte and its valid flag, passes them on to the next cell on
// every accepted transaction and compares the byte with its pattern character.
// ----------------------------------------------------------------------------
`default_nettype none

module som_cell
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire som_pkg::cell_ctrl_t ctrl,
    input  wire som_pkg::link_t     link_in,
    input  wire logic [7:0]         ref_byte,
    input  wire logic               in_use,
    output som_pkg::link_t          link_out,
    output logic                    ok
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;
    logic [7:0] data_next;

    // Shift in from the neighbour; end of text empties the cell.
    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (ctrl.shift)
        begin
            valid_next = link_in.valid && !ctrl.clear;
            data_next  = link_in.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    // A cell outside the current pattern length never blocks a match.
    assign ok = !in_use || (valid_reg && (data_reg == ref_byte));

    assign link_out.valid = valid_reg;
    assign link_out.data  = data_reg;

endmodule

`default_nettype wire

@@ rtl/som_tracker.sv @@
// ----------------------------------------------------------------------------
// som_tracker: per-string occurrence bookkeeping
// Keeps the byte position, the saturating occurrence count and the first
// occurrence, and forms the result fields for the current byte.
// ----------------------------------------------------------------------------
`default_nettype none

module som_tracker
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire som_pkg::cell_ctrl_t           ctrl,
    input  wire logic                          hit,
    input  wire logic [som_pkg::LEN_BITS-1:0]  eff_len,
    output som_pkg::track_res_t                res
);

    som_pkg::position_t                     position_reg;
    som_pkg::position_t                     position_next;
    logic [som_pkg::COUNT_BITS-1:0]         count_reg;
    logic [som_pkg::COUNT_BITS-1:0]         count_next;
    logic                                   found_reg;
    logic                                   found_next;
    som_pkg::position_t                     first_reg;
    som_pkg::position_t                     first_next;
    som_pkg::position_t                     start_pos;
    logic [som_pkg::COUNT_BITS-1:0]         count_upd;
    som_pkg::position_t                     first_upd;

    // Start of an occurrence ending at the current byte, modulo the position range.
    assign start_pos = position_reg
                     - som_pkg::POSITION_BITS'(eff_len - som_pkg::LEN_BITS'(1));

    // Values after counting the current byte
    always_comb
    begin
        count_upd = count_reg;
        if (hit && (count_reg != som_pkg::COUNT_MAX))
        begin
            count_upd = count_reg + som_pkg::COUNT_BITS'(1);
        end
        first_upd = first_reg;
        if (hit && !found_reg)
        begin
            first_upd = start_pos;
        end
    end

    // Result fields for this transaction
    always_comb
    begin
        res.match_found = hit;
        res.match_start = hit ? som_pkg::REPORT_BITS'(start_pos) : '0;
        res.match_count = count_upd;
        res.found_any   = found_reg || hit;
        res.first_start = som_pkg::REPORT_BITS'(first_upd);
    end

    // State update on each accepted byte; end of text starts a fresh string.
    always_comb
    begin
        position_next = position_reg;
        count_next    = count_reg;
        found_next    = found_reg;
        first_next    = first_reg;
        if (ctrl.shift)
        begin
            if (ctrl.clear)
            begin
                position_next = '0;
                count_next    = '0;
                found_next    = 1'b0;
                first_next    = '0;
            end
            else
            begin
                position_next = position_reg + som_pkg::POSITION_BITS'(1);
                count_next    = count_upd;
                found_next    = found_reg || hit;
                first_next    = first_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg <= '0;
            count_reg    <= '0;
            found_reg    <= 1'b0;
            first_reg    <= '0;
        end
        else
        begin
            position_reg <= position_next;
            count_reg    <= count_next;
            found_reg    <= found_next;
            first_reg    <= first_next;
        end
    end

endmodule

`default_nettype wire

@@ tb/substring_occurrence_matcher_core_test.sv @@
// ----------------------------------------------------------------------------
// substring_occurrence_matcher_core_test: self-checking bench for the matcher
// Opens with a table of directed text bytes and register writes. Typed
// expectations cover the reset state, clamped lengths and string clearing.
// Random phases follow, built mostly from copies of the pattern with some
// noise. Every result is checked against its typed expectation or an in-bench
// search model, with random idling on both channels and one long output stall.
// ----------------------------------------------------------------------------
`default_nettype none

module substring_occurrence_matcher_core_test;

    // One result transaction as the block presents it
    typedef struct packed {
        logic        match_found;
        logic [15:0] match_start;
        logic [15:0] match_count;
        logic        found_any;
        logic [15:0] first_start;
        logic        is_last;
    } result_t;

    typedef enum logic [1:0] {
        ROW_TEXT,
        ROW_SET_PATTERN,
        ROW_SET_LENGTH
    } row_kind_t;

    // Row of the directed table: a text byte, or a register write
    typedef struct packed {
        row_kind_t                         kind;
        logic [som_pkg::CFG_DATA_BITS-1:0] data;
        logic                              eot;
        logic                              typed;
        result_t                           value;
    } stim_row_t;

    // Typed expectation, if any, that goes with each offered byte
    typedef struct packed {
        logic    typed;
        result_t value;
    } typed_row_t;

    localparam int      NUM_DIRECTED      = 30;
    localparam int      RANDOM_PHASES     = 6;
    localparam int      PHASE_BYTES       = 105;
    localparam int      LONG_STALL_CYCLES = 250;
    localparam result_t NO_RESULT         = '0;

    logic                               clk = 1'b0;
    logic                               rst_n;
    logic                               cfg_write_en;
    logic [som_pkg::CFG_INDEX_BITS-1:0] cfg_index;
    logic [som_pkg::CFG_DATA_BITS-1:0]  cfg_data;

    som_text_if   text_bus ();
    som_result_if result_bus ();

    substring_occurrence_matcher_core u_top
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .text_in      (text_bus),
        .result_out   (result_bus),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Copy of the registers and of the per-string search state
    logic [som_pkg::CFG_DATA_BITS-1:0] pattern_reg = '0;
    logic [som_pkg::LEN_BITS-1:0]      length_reg  = som_pkg::PATTERN_LENGTH_RST;
    logic [55:0]                       win_hist    = '0;
    logic [15:0]                       next_pos    = '0;
    logic [15:0]                       occ_total   = '0;
    logic                              seen_first  = 1'b0;
    logic [15:0]                       first_pos   = '0;
    int                                win_fill    = 0;

    result_t    pending_results [$];
    typed_row_t typed_rows [$];

    int   errors        = 0;
    int   bytes_sent    = 0;
    int   strings_done  = 0;
    int   occurrences   = 0;
    int   reg_writes    = 0;
    int   src_idle_pct  = 0;
    int   sink_idle_pct = 0;
    logic long_stall_pending = 1'b0;

    stim_row_t directed_rows [NUM_DIRECTED] = '{
        // Reset pattern is a single zero byte
        '{ROW_TEXT, 64'h00, 1'b0, 1'b1, '{1'b1, 16'd0, 16'd1, 1'b1, 16'd0, 1'b0}},
        '{ROW_TEXT, 64'hFF, 1'b1, 1'b1, '{1'b0, 16'd0, 16'd1, 1'b1, 16'd0, 1'b1}},
        // A length of zero behaves as a length of one
        '{ROW_SET_LENGTH,  64'd0,  1'b0, 1'b0, '0},
        '{ROW_SET_PATTERN, 64'hFF, 1'b0, 1'b0, '0},
        '{ROW_TEXT, 64'hFF, 1'b0, 1'b1, '{1'b1, 16'd0, 16'd1, 1'b1, 16'd0, 1'b0}},
        '{ROW_TEXT, 64'hFF, 1'b1, 1'b1, '{1'b1, 16'd1, 16'd2, 1'b1, 16'd0, 1'b1}},
        // An oversized length is clamped to eight, with overlapping hits
        '{ROW_SET_LENGTH,  64'd15,                 1'b0, 1'b0, '0},
        '{ROW_SET_PATTERN, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, '0},
        '{ROW_TEXT, 64'hFF, 1'b0, 1'b0, '0},
        '{ROW_TEXT, 64'hFF, 1'b0, 1'b0, '0},
        '{ROW_TEXT, 64'hFF, 1'b0, 1'b0, '0},
        '{ROW_TEXT, 64'hFF, 1'b0, 1'b0, '0},
        '{ROW_TEXT, 64'hFF, 1'b0, 1'b0, '0},
        '{ROW_TEXT, 64'hFF, 1'b0, 1'b0, '0},
        '{ROW_TEXT, 64'hFF, 1'b0, 1'b0, '0},
        '{ROW_TEXT, 64'hFF, 1'b0, 1'b0, '0},
        '{ROW_TEXT, 64'hFF, 1'b1, 1'b0, '0},
        // Three-byte pattern with unused upper bytes set
        '{ROW_SET_LENGTH,  64'd3,                  1'b0, 1'b0, '0},
        '{ROW_SET_PATTERN, 64'hA5A5_A5A5_A561_6261, 1'b0, 1'b0, '0},
        '{ROW_TEXT, 64'h61, 1'b0, 1'b0, '0},
        '{ROW_TEXT, 64'h62, 1'b0, 1'b0, '0},
        '{ROW_TEXT, 64'h61, 1'b0, 1'b0, '0},
        '{ROW_TEXT, 64'h62, 1'b0, 1'b0, '0},
        '{ROW_TEXT, 64'h61, 1'b1, 1'b0, '0},
        // Zero bytes are ordinary characters in both pattern and text
        '{ROW_SET_LENGTH,  64'd2, 1'b0, 1'b0, '0},
        '{ROW_SET_PATTERN, 64'd0, 1'b0, 1'b0, '0},
        '{ROW_TEXT, 64'h00, 1'b0, 1'b0, '0},
        '{ROW_TEXT, 64'h00, 1'b0, 1'b0, '0},
        '{ROW_TEXT, 64'h00, 1'b1, 1'b0, '0},
        // After the end of a string the window starts empty again
        '{ROW_TEXT, 64'h00, 1'b1, 1'b1, '{1'b0, 16'd0, 16'd0, 1'b0, 16'd0, 1'b1}}
    };

    // Length code as the block uses it
    function automatic int clamp_length(input logic [som_pkg::LEN_BITS-1:0] code);
        int len;
        len = int'(code);
        if (len < 1)
        begin
            len = 1;
        end
        else if (len > som_pkg::MAX_PATTERN)
        begin
            len = som_pkg::MAX_PATTERN;
        end
        return len;
    endfunction

    // Search step for one accepted byte; updates the string state
    function automatic result_t predict_occurrence(input logic [7:0] b, input logic eot);
        result_t    r;
        int         len;
        logic       hit;
        logic [7:0] tb;
        r   = NO_RESULT;
        len = clamp_length(length_reg);
        hit = (win_fill >= len - 1);
        for (int i = 0; i < len && hit; i++)
        begin
            if (i == len - 1)
            begin
                tb = b;
            end
            else
            begin
                tb = win_hist[8 * (len - 2 - i) +: 8];
            end
            if (pattern_reg[8 * i +: 8] != tb)
            begin
                hit = 1'b0;
            end
        end
        if (hit)
        begin
            r.match_found = 1'b1;
            r.match_start = next_pos - 16'(len - 1);
            if (occ_total != som_pkg::COUNT_MAX)
            begin
                occ_total = occ_total + 16'd1;
            end
            if (!seen_first)
            begin
                seen_first = 1'b1;
                first_pos  = r.match_start;
            end
        end
        r.match_count = occ_total;
        r.found_any   = seen_first;
        r.first_start = first_pos;
        r.is_last     = eot;
        // The last byte of a string clears everything but the registers
        if (eot)
        begin
            win_hist   = '0;
            next_pos   = '0;
            occ_total  = '0;
            seen_first = 1'b0;
            first_pos  = '0;
            win_fill   = 0;
        end
        else
        begin
            win_hist = {win_hist[47:0], b};
            if (win_fill < som_pkg::MAX_PATTERN - 1)
            begin
                win_fill++;
            end
            next_pos = next_pos + 16'd1;
        end
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [15:0] want,
                                 input logic [15:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    // Register write at one rising edge, mirrored into the local copy
    task automatic write_reg(input logic [som_pkg::CFG_INDEX_BITS-1:0] idx,
                             input logic [som_pkg::CFG_DATA_BITS-1:0] value);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= value;
        @(posedge clk);
        if (idx == som_pkg::REG_PATTERN_BYTES)
        begin
            pattern_reg = value;
        end
        else
        begin
            length_reg = value[som_pkg::LEN_BITS-1:0];
        end
        reg_writes++;
        cfg_write_en <= 1'b0;
        @(posedge clk);
    endtask

    // Offers one text byte, idling first at random, until it is accepted
    task automatic send_text(input logic [7:0] b, input logic eot, input logic typed,
                             input result_t value);
        typed_row_t tr;
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            text_bus.valid <= 1'b0;
            @(posedge clk);
        end
        tr.typed = typed;
        tr.value = value;
        typed_rows.push_back(tr);
        text_bus.valid       <= 1'b1;
        text_bus.text_byte   <= b;
        text_bus.end_of_text <= eot;
        @(posedge clk);
        while (!text_bus.ready)
        begin
            @(posedge clk);
        end
        bytes_sent++;
    endtask

    // Stops offering and waits until every result has come back
    task automatic drain_results();
        text_bus.valid <= 1'b0;
        while (pending_results.size() != 0 || typed_rows.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (2) @(posedge clk);
    endtask

    // Free-running clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Watches both channels at each edge and drives the result ready
    initial
    begin
        result_t    want;
        result_t    got;
        typed_row_t row;
        int         stall_left;
        stall_left = 0;
        result_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            // Result transaction against the oldest expectation
            if (rst_n && result_bus.valid && result_bus.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: result with nothing expected, expected none, actual count %0h",
                             $time, result_bus.match_count);
                end
                else
                begin
                    want = pending_results.pop_front();
                    compare_field("match_found", 16'(want.match_found),
                                  16'(result_bus.match_found));
                    compare_field("match_start", want.match_start, result_bus.match_start);
                    compare_field("match_count", want.match_count, result_bus.match_count);
                    compare_field("found_any", 16'(want.found_any), 16'(result_bus.found_any));
                    compare_field("first_start", want.first_start, result_bus.first_start);
                    compare_field("is_last", 16'(want.is_last), 16'(result_bus.is_last));
                    if (want.match_found)
                    begin
                        occurrences++;
                    end
                    if (want.is_last)
                    begin
                        strings_done++;
                    end
                end
            end
            // Text transaction: predict its result
            if (rst_n && text_bus.valid && text_bus.ready)
            begin
                row = typed_rows.pop_front();
                got = predict_occurrence(text_bus.text_byte, text_bus.end_of_text);
                pending_results.push_back(row.typed ? row.value : got);
            end
            // Ready for the next cycle, with one long hold-off on request
            if (long_stall_pending && stall_left == 0)
            begin
                stall_left = LONG_STALL_CYCLES;
                long_stall_pending <= 1'b0;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                result_bus.ready <= 1'b0;
            end
            else
            begin
                result_bus.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
            end
        end
    end

    // Stimulus: directed table, then random phases
    initial
    begin
        int                                len;
        int                                sent;
        int                                seg;
        int                                pick;
        logic [som_pkg::LEN_BITS-1:0]      len_code;
        logic [som_pkg::CFG_DATA_BITS-1:0] pat;
        logic [7:0]                        b;

        rst_n                <= 1'b0;
        cfg_write_en         <= 1'b0;
        cfg_index            <= '0;
        cfg_data             <= '0;
        text_bus.valid       <= 1'b0;
        text_bus.text_byte   <= '0;
        text_bus.end_of_text <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table
        src_idle_pct = 27;
        sink_idle_pct <= 47;
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_TEXT)
            begin
                send_text(directed_rows[i].data[7:0], directed_rows[i].eot,
                          directed_rows[i].typed, directed_rows[i].value);
            end
            else
            begin
                drain_results();
                write_reg((directed_rows[i].kind == ROW_SET_PATTERN) ?
                          som_pkg::REG_PATTERN_BYTES : som_pkg::REG_PATTERN_LENGTH,
                          directed_rows[i].data);
            end
        end

        // Random phases, each with fresh register settings
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            drain_results();
            case (phase / 2)
                0:
                begin
                    src_idle_pct = 27;
                    sink_idle_pct <= 47;
                end
                1:
                begin
                    src_idle_pct = 47;
                    sink_idle_pct <= 27;
                end
                default:
                begin
                    src_idle_pct = 0;
                    sink_idle_pct <= 0;
                end
            endcase
            case (phase)
                0:       len_code = 4'd1;
                1:       len_code = 4'd8;
                2:       len_code = 4'd0;
                3:       len_code = 4'd15;
                4:       len_code = 4'($urandom_range(2, 7));
                default: len_code = 4'($urandom_range(1, 8));
            endcase
            // Patterns from a small alphabet, or wholly random
            if (phase == 2 || phase == 5)
            begin
                pat = {$urandom, $urandom};
            end
            else
            begin
                for (int k = 0; k < som_pkg::MAX_PATTERN; k++)
                begin
                    case ($urandom_range(0, 4))
                        0:       pat[8 * k +: 8] = 8'h61;
                        1:       pat[8 * k +: 8] = 8'h62;
                        2:       pat[8 * k +: 8] = 8'h00;
                        3:       pat[8 * k +: 8] = 8'hFF;
                        default: pat[8 * k +: 8] = 8'($urandom);
                    endcase
                end
            end
            write_reg(som_pkg::REG_PATTERN_LENGTH, som_pkg::CFG_DATA_BITS'(len_code));
            write_reg(som_pkg::REG_PATTERN_BYTES, pat);
            len = clamp_length(len_code);
            if (phase == 2)
            begin
                long_stall_pending <= 1'b1;
            end
            // Whole copies of the pattern, broken prefixes and noise bytes
            sent = 0;
            while (sent < PHASE_BYTES)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 5)
                begin
                    seg = len;
                end
                else if (pick < 7)
                begin
                    seg = $urandom_range(1, len);
                end
                else
                begin
                    seg = 0;
                end
                if (seg == 0)
                begin
                    case ($urandom_range(0, 3))
                        0:       b = pat[8 * $urandom_range(0, len - 1) +: 8];
                        1:       b = 8'h00;
                        2:       b = 8'hFF;
                        default: b = 8'($urandom);
                    endcase
                    send_text(b, ($urandom_range(0, 24) == 0), 1'b0, NO_RESULT);
                    sent++;
                end
                else
                begin
                    for (int k = 0; k < seg; k++)
                    begin
                        send_text(pat[8 * k +: 8], ($urandom_range(0, 24) == 0), 1'b0,
                                  NO_RESULT);
                        sent++;
                    end
                end
            end
        end
        drain_results();

        $display("Checked %0d text transactions in %0d strings, %0d occurrences, %0d writes.",
                 bytes_sent, strings_done, occurrences, reg_writes);
        $display("Lengths 0 to 15, overlapping hits, string clearing and stalls exercised.");
        if (errors == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

    // Watchdog against a hung handshake
    initial
    begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire
